// ----- hdl/uos_pkg.sv -----
// ----------------------------------------------------------------------------
// uos_pkg
// Shared types, constants and lookup functions for the UTF-8 overlong
// sequence sanitizer.
// ----------------------------------------------------------------------------
package uos_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned JOB_SLOTS   = 6;   // most words one input byte can cause
	localparam int unsigned CNT_W       = 3;   // holds 0..JOB_SLOTS
	localparam int unsigned HELD_DEPTH  = 4;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [BYTE_W-1:0] QMARK     = 8'h3F;
	localparam logic [BYTE_W-1:0] CONT_LO   = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_HI   = 8'hBF;
	localparam logic [BYTE_W-1:0] E0_HI     = 8'h9F;
	localparam logic [BYTE_W-1:0] F0_HI     = 8'h8F;
	localparam logic [BYTE_W-1:0] F4_LO     = 8'h90;

	// Sequence class, named after the lowest lead byte of each group
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_C0,
		CLS_E0,
		CLS_F0,
		CLS_F4,
		CLS_F5,
		CLS_F8,
		CLS_FC
	} seq_class_t;

	// One run of output words caused by one input word
	typedef struct packed {
		logic [JOB_SLOTS-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]                 count;
		logic                             rep;
	} job_t;

	function automatic seq_class_t classify(input logic [BYTE_W-1:0] b);
		seq_class_t c;
		case (b) inside
			8'hC0, 8'hC1:   c = CLS_C0;
			8'hE0:          c = CLS_E0;
			8'hF0:          c = CLS_F0;
			8'hF4:          c = CLS_F4;
			[8'hF5:8'hF7]:  c = CLS_F5;
			[8'hF8:8'hFB]:  c = CLS_F8;
			[8'hFC:8'hFD]:  c = CLS_FC;
			default:        c = CLS_NONE;
		endcase
		return c;
	endfunction

	// continuation bytes that complete a sequence
	function automatic logic [CNT_W-1:0] needed(input seq_class_t c);
		logic [CNT_W-1:0] n;
		case (c)
			CLS_NONE: n = 3'd0;
			CLS_C0:   n = 3'd1;
			CLS_E0:   n = 3'd2;
			CLS_F0:   n = 3'd3;
			CLS_F4:   n = 3'd3;
			CLS_F5:   n = 3'd3;
			CLS_F8:   n = 3'd4;
			CLS_FC:   n = 3'd5;
			default:  n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [BYTE_W-1:0] first_lo(input seq_class_t c);
		logic [BYTE_W-1:0] v;
		case (c)
			CLS_F4:  v = F4_LO;
			default: v = CONT_LO;
		endcase
		return v;
	endfunction

	function automatic logic [BYTE_W-1:0] first_hi(input seq_class_t c);
		logic [BYTE_W-1:0] v;
		case (c)
			CLS_E0:  v = E0_HI;
			CLS_F0:  v = F0_HI;
			default: v = CONT_HI;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/utf8_overlong_sanitizer.sv -----
// ----------------------------------------------------------------------------
// utf8_overlong_sanitizer
// Streams UTF-8 bytes through, replacing overlong and above-U+10FFFF
// sequences with a single '?'.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one word (in_byte, end_of_string).
// Output channel: out_valid/out_ready carry one word (out_byte, replaced,
// last_of_run); last_of_run marks the final word caused by one input word.
// An input word causes 0 to 6 output words. Bytes of a suspect sequence are
// held in the front until it completes (one '?' word, replaced set), breaks
// (held bytes go out unchanged) or end_of_string flushes them.
// A word that causes output is written into the run queue when accepted and
// shows on out_* once the runs ahead of it have gone out. The front takes one
// input word per cycle until the run queue fills; the back half sends one
// output word per cycle while out_ready is high, popping a run after its last
// word. A stalled receiver backs up into in_ready after QUEUE_DEPTH runs.
// Reset (arst_n low) drops all held bytes and queued runs.
// ----------------------------------------------------------------------------
module utf8_overlong_sanitizer #(
	parameter int unsigned QUEUE_DEPTH = uos_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [uos_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        end_of_string,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [uos_pkg::BYTE_W-1:0]  out_byte,
	output logic                        replaced,
	output logic                        last_of_run
);

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	uos_pkg::job_t q_job;
	uos_pkg::job_t q_head;

	uos_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (q_job)
	);

	uos_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	uos_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.replaced    (replaced),
		.last_of_run (last_of_run)
	);

endmodule

// ----- hdl/uos_front.sv -----
// ----------------------------------------------------------------------------
// uos_front
// Classifies each input byte against the held sequence, keeps the sequence
// state and builds the run of output words the byte causes.
// ----------------------------------------------------------------------------
module uos_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [uos_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        end_of_string,
	input  logic                        q_full,
	output logic                        q_push,
	output uos_pkg::job_t               q_job
);

	uos_pkg::seq_class_t               class_q;
	logic [uos_pkg::CNT_W-1:0]         hc_q;
	logic [uos_pkg::BYTE_W-1:0]        lead_q;
	logic [uos_pkg::BYTE_W-1:0]        held_q [uos_pkg::HELD_DEPTH];

	uos_pkg::seq_class_t               cls_in;
	logic                              accept;
	logic                              pend;
	logic                              match;
	logic                              complete;
	logic                              prefix;
	logic                              append_b;
	logic [uos_pkg::CNT_W-1:0]         need;
	logic [uos_pkg::CNT_W-1:0]         pos;
	logic [uos_pkg::BYTE_W-1:0]        lo;
	logic [uos_pkg::BYTE_W-1:0]        hi;
	uos_pkg::job_t                     job;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cls_in   = uos_pkg::classify(in_byte);
		pend     = (class_q != uos_pkg::CLS_NONE);
		need     = uos_pkg::needed(class_q);
		lo       = (hc_q == '0) ? uos_pkg::first_lo(class_q) : uos_pkg::CONT_LO;
		hi       = (hc_q == '0) ? uos_pkg::first_hi(class_q) : uos_pkg::CONT_HI;
		match    = pend && (in_byte >= lo) && (in_byte <= hi) && (hc_q < need);
		complete = match && ((hc_q + 3'd1) == need);
		// held lead and continuations go out when broken, or on end of string
		prefix   = pend && (!match || (end_of_string && !complete));
		append_b = match ? (end_of_string && !complete)
		                 : ((cls_in == uos_pkg::CLS_NONE) || end_of_string);
		pos      = prefix ? (hc_q + 3'd1) : 3'd0;

		job.bytes[0] = lead_q;
		for (int i = 1; i <= uos_pkg::HELD_DEPTH; i++) begin
			job.bytes[i] = held_q[i-1];
		end
		job.bytes[uos_pkg::JOB_SLOTS-1] = in_byte;
		for (int i = 0; i < uos_pkg::JOB_SLOTS; i++) begin
			if (pos == 3'(i)) begin
				job.bytes[i] = in_byte;
			end
		end
		job.count = (prefix ? (hc_q + 3'd1) : 3'd0) + {2'b00, append_b};
		job.rep   = 1'b0;
		if (complete) begin
			job.bytes[0] = uos_pkg::QMARK;
			job.count    = 3'd1;
			job.rep      = 1'b1;
		end
	end

	assign q_job  = job;
	assign q_push = accept && (job.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= uos_pkg::CLS_NONE;
			hc_q    <= '0;
		end else if (accept) begin
			if (match) begin
				if (complete || end_of_string) begin
					class_q <= uos_pkg::CLS_NONE;
					hc_q    <= '0;
				end else begin
					hc_q <= hc_q + 3'd1;
				end
			end else begin
				class_q <= end_of_string ? uos_pkg::CLS_NONE : cls_in;
				hc_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && match && !complete) begin
			held_q[hc_q[1:0]] <= in_byte;
		end
		if (accept && !match) begin
			lead_q <= in_byte;
		end
	end

endmodule

// ----- hdl/uos_queue.sv -----
// ----------------------------------------------------------------------------
// uos_queue
// Small FIFO of output runs between the front and back halves.
// ----------------------------------------------------------------------------
module uos_queue #(
	parameter int unsigned DEPTH = uos_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  uos_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output uos_pkg::job_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LVL_W = $clog2(DEPTH + 1);

	uos_pkg::job_t     mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/uos_back.sv -----
// ----------------------------------------------------------------------------
// uos_back
// Walks the head run of the queue, one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module uos_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  uos_pkg::job_t               q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [uos_pkg::BYTE_W-1:0]  out_byte,
	output logic                        replaced,
	output logic                        last_of_run
);

	logic [uos_pkg::CNT_W-1:0] idx_q;
	logic                      take;

	assign out_valid   = !q_empty;
	assign out_byte    = q_head.bytes[idx_q];
	assign replaced    = q_head.rep;
	assign last_of_run = (idx_q == (q_head.count - 3'd1));
	assign take        = out_valid && out_ready;
	assign q_pop       = take && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= last_of_run ? '0 : idx_q + 3'd1;
		end
	end

endmodule

// ----- hdl/uos_checker.sv -----
// ----------------------------------------------------------------------------
// uos_checker
// Port-level checks for the sanitizer, bound onto the top level.
// ----------------------------------------------------------------------------
module uos_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       end_of_string,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       replaced,
	input logic       last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(out_byte) && $stable(replaced) && $stable(last_of_run))
		else $error("output word changed while stalled");

	// a replacement is always a one-word run of '?'
	a_rep_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && replaced |-> (out_byte == 8'h3F) && last_of_run)
		else $error("replacement word malformed");

	// nothing queued means room for input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output side");

endmodule

bind utf8_overlong_sanitizer uos_checker u_uos_checker (.*);

// ----- tb/utf8_overlong_sanitizer_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_overlong_sanitizer_tb
// Streams byte words through the sanitizer and checks every output word
// against an in-bench predictor of the held-sequence logic. A directed pass
// covers pass-through bytes, replaced C0/E0/F4/FC sequences, broken sequences
// and end-of-string flushes. A random pass then mixes well-formed suspect
// sequences, broken ones and noise, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module utf8_overlong_sanitizer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] b;
		logic       rep;
		logic       last;
	} out_word_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       end_of_string;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       replaced;
	logic       last_of_run;

	// predictor state
	logic [7:0]           sus_lead;
	uos_pkg::seq_class_t  sus_cls;
	int unsigned          sus_held_n;
	logic [7:0]           sus_held [4];

	out_word_t sanitized_q [$];
	out_word_t run_words [$];

	int unsigned errors = 0;
	int unsigned bytes_sent = 0;
	int unsigned words_checked = 0;
	int unsigned qmarks_seen = 0;
	int unsigned eos_sent = 0;
	logic        quiet = 1'b0;
	int unsigned rdy_left = 0;
	logic        rdy_level = 1'b0;

	utf8_overlong_sanitizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.replaced      (replaced),
		.last_of_run   (last_of_run)
	);

	always #6 clk = ~clk;

	task automatic report(input string what);
		errors++;
		$display("[%0t] ERROR %s", $time, what);
	endtask

	function automatic uos_pkg::seq_class_t lead_class(input logic [7:0] b);
		if (b == 8'hC0 || b == 8'hC1) return uos_pkg::CLS_C0;
		if (b == 8'hE0) return uos_pkg::CLS_E0;
		if (b == 8'hF0) return uos_pkg::CLS_F0;
		if (b == 8'hF4) return uos_pkg::CLS_F4;
		if (b >= 8'hF5 && b <= 8'hF7) return uos_pkg::CLS_F5;
		if (b >= 8'hF8 && b <= 8'hFB) return uos_pkg::CLS_F8;
		if (b == 8'hFC || b == 8'hFD) return uos_pkg::CLS_FC;
		return uos_pkg::CLS_NONE;
	endfunction

	function automatic int unsigned conts_needed(input uos_pkg::seq_class_t c);
		case (c)
			uos_pkg::CLS_C0:  return 1;
			uos_pkg::CLS_E0:  return 2;
			uos_pkg::CLS_F0,
			uos_pkg::CLS_F4,
			uos_pkg::CLS_F5:  return 3;
			uos_pkg::CLS_F8:  return 4;
			uos_pkg::CLS_FC:  return 5;
			default:          return 0;
		endcase
	endfunction

	// allowed range of the first continuation byte
	function automatic void cont1_range(input uos_pkg::seq_class_t c,
			output logic [7:0] lo, output logic [7:0] hi);
		lo = (c == uos_pkg::CLS_F4) ? 8'h90 : 8'h80;
		case (c)
			uos_pkg::CLS_E0:  hi = 8'h9F;
			uos_pkg::CLS_F0:  hi = 8'h8F;
			default:          hi = 8'hBF;
		endcase
	endfunction

	function automatic void add_word(input logic [7:0] b, input logic rep);
		out_word_t w;
		w.b = b;
		w.rep = rep;
		w.last = 1'b0;
		if (run_words.size() < 6)
			run_words.push_back(w);
	endfunction

	function automatic void drop_suspect();
		sus_cls = uos_pkg::CLS_NONE;
		sus_lead = 8'h00;
		sus_held_n = 0;
	endfunction

	function automatic void flush_suspect();
		if (sus_cls == uos_pkg::CLS_NONE)
			return;
		add_word(sus_lead, 1'b0);
		for (int unsigned i = 0; i < sus_held_n && i < 4; i++)
			add_word(sus_held[i], 1'b0);
		drop_suspect();
	endfunction

	// expected output words for one accepted input byte
	task automatic sanitize_byte(input logic [7:0] b, input logic eos);
		logic [7:0] lo, hi;
		uos_pkg::seq_class_t c;
		logic       taken;
		run_words.delete();
		taken = 1'b0;
		if (sus_cls != uos_pkg::CLS_NONE) begin
			if (sus_held_n == 0) begin
				cont1_range(sus_cls, lo, hi);
			end else begin
				lo = 8'h80;
				hi = 8'hBF;
			end
			if (b >= lo && b <= hi && sus_held_n < conts_needed(sus_cls)) begin
				if (sus_held_n + 1 == conts_needed(sus_cls)) begin
					add_word(uos_pkg::QMARK, 1'b1);
					drop_suspect();
				end else begin
					if (sus_held_n < 4)
						sus_held[sus_held_n] = b;
					sus_held_n++;
				end
				taken = 1'b1;
			end else begin
				flush_suspect();
			end
		end
		if (!taken) begin
			c = lead_class(b);
			if (c != uos_pkg::CLS_NONE) begin
				sus_cls = c;
				sus_lead = b;
				sus_held_n = 0;
			end else begin
				add_word(b, 1'b0);
			end
		end
		if (eos)
			flush_suspect();
		if (run_words.size() > 0)
			run_words[run_words.size()-1].last = 1'b1;
		foreach (run_words[i])
			sanitized_q.push_back(run_words[i]);
	endtask

	task automatic send_word(input logic [7:0] b, input logic eos);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_string <= eos;
		do @(posedge clk); while (!in_ready);
		sanitize_byte(b, eos);
		bytes_sent++;
		if (eos)
			eos_sent++;
	endtask

	function automatic logic [7:0] rand_lead(input uos_pkg::seq_class_t c);
		case (c)
			uos_pkg::CLS_C0:  return 8'hC0 + 8'($urandom_range(0, 1));
			uos_pkg::CLS_E0:  return 8'hE0;
			uos_pkg::CLS_F0:  return 8'hF0;
			uos_pkg::CLS_F4:  return 8'hF4;
			uos_pkg::CLS_F5:  return 8'hF5 + 8'($urandom_range(0, 2));
			uos_pkg::CLS_F8:  return 8'hF8 + 8'($urandom_range(0, 3));
			default:          return 8'hFC + 8'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic logic rand_eos();
		return ($urandom_range(0, 11) == 0);
	endfunction

	// lead, n_conts in-range continuations, then optionally a breaking byte
	task automatic send_suspect(input uos_pkg::seq_class_t c, input int unsigned n_conts,
			input logic break_it);
		logic [7:0] lo, hi;
		send_word(rand_lead(c), rand_eos());
		cont1_range(c, lo, hi);
		for (int unsigned i = 0; i < n_conts; i++) begin
			send_word(8'($urandom_range(lo, hi)), rand_eos());
			lo = 8'h80;
			hi = 8'hBF;
		end
		if (break_it) begin
			if ($urandom_range(0, 2) == 0)
				send_word(rand_lead(uos_pkg::seq_class_t'($urandom_range(1, 7))),
					rand_eos());
			else
				send_word(8'($urandom_range(0, 255)), rand_eos());
		end
	endtask

	task automatic random_mix(input int unsigned stop_at);
		uos_pkg::seq_class_t c;
		int unsigned         pick;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 9);
			c = uos_pkg::seq_class_t'($urandom_range(1, 7));
			if (pick < 6) begin
				send_suspect(c, conts_needed(c), 1'b0);
			end else if (pick < 8) begin
				send_suspect(c, $urandom_range(0, conts_needed(c) - 1), 1'b1);
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(8'($urandom_range(0, 255)), rand_eos());
			end
		end
	endtask

	task automatic test_pass_through();
		send_word(8'h00, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'h80, 1'b0);  // continuation with nothing held
		send_word(8'hFF, 1'b0);
	endtask

	task automatic test_overlong_replace();
		send_word(8'hC0, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hE0, 1'b0);
		send_word(8'h9F, 1'b0);
		send_word(8'hBF, 1'b0);
		send_word(8'hF4, 1'b0);
		send_word(8'h90, 1'b0);
		send_word(8'hBF, 1'b0);
		send_word(8'hBF, 1'b1);  // completes and ends the string together
		send_word(8'hFD, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hBF, 1'b0);
	endtask

	task automatic test_broken_sequence();
		send_word(8'hF8, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hC1, 1'b0);  // breaks F8 run, opens a new one
		send_word(8'h7F, 1'b0);  // breaks C1
	endtask

	task automatic test_end_flush();
		send_word(8'hFC, 1'b1);  // lead flushed in the same step
		send_word(8'hF5, 1'b0);
		send_word(8'hBF, 1'b1);
	endtask

	task automatic test_random_traffic();
		random_mix(145);
	endtask

	// last stretch: no idling on either side
	task automatic test_streaming();
		quiet = 1'b1;
		random_mix(172);
	endtask

	always @(negedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else begin
			if (rdy_left == 0) begin
				rdy_level = ($urandom_range(0, 2) != 0);
				rdy_left = rdy_level ? $urandom_range(1, 40) : $urandom_range(1, 17);
			end
			rdy_left = rdy_left - 1;
			out_ready <= rdy_level;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (sanitized_q.size() == 0) begin
				report($sformatf("unexpected word %02h", out_byte));
			end else begin
				if (out_byte !== sanitized_q[0].b)
					report($sformatf("out_byte got %02h expected %02h",
						out_byte, sanitized_q[0].b));
				if (replaced !== sanitized_q[0].rep)
					report($sformatf("replaced got %b expected %b",
						replaced, sanitized_q[0].rep));
				if (last_of_run !== sanitized_q[0].last)
					report($sformatf("last_of_run got %b expected %b",
						last_of_run, sanitized_q[0].last));
				if (sanitized_q[0].rep)
					qmarks_seen++;
				void'(sanitized_q.pop_front());
				words_checked++;
			end
		end
	end

	initial begin
		#5000000;
		$display("TIMEOUT at %0t", $time);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		end_of_string = 1'b0;
		out_ready = 1'b0;
		sus_held = '{default: 8'h00};
		drop_suspect();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pass_through();
		test_overlong_replace();
		test_broken_sequence();
		test_end_flush();
		test_random_traffic();
		test_streaming();

		@(negedge clk);
		in_valid <= 1'b0;
		while (sanitized_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d input bytes (%0d with end_of_string), %0d output words,",
			bytes_sent, eos_sent, words_checked);
		$display("%0d of them replacement marks.", qmarks_seen);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/uos_pkg.sv
hdl/uos_front.sv
hdl/uos_queue.sv
hdl/uos_back.sv
hdl/utf8_overlong_sanitizer.sv
hdl/uos_checker.sv
tb/utf8_overlong_sanitizer_tb.sv
